// File: rtl/pfa_pkg.sv
// ----------------------------------------------------------------------------
// pfa_pkg - partition fit allocator shared definitions
// Default sizes, transaction codes, placement modes and register indexes.
// ----------------------------------------------------------------------------
package pfa_pkg;

    localparam int DEF_PARTITIONS = 16;
    localparam int DEF_SIZE_BITS  = 16;

    // input field widths
    localparam int FUNC_W  = 1;
    localparam int PIDX_W  = 4;
    localparam int SIZE_W  = 16;

    // output field widths
    localparam int STATUS_W = 2;

    // config port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;
    localparam int MODE_W     = 2;
    localparam int NUMP_W     = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_ALLOC_MODE     = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_PARTITIONS = 1'd1;

    localparam logic [MODE_W-1:0]   MODE_RESET = 2'd0;
    localparam logic [NUMP_W-1:0]   NUMP_RESET = 5'd16;

    // transaction kinds
    localparam logic [FUNC_W-1:0] FUNC_LOAD    = 1'b0;
    localparam logic [FUNC_W-1:0] FUNC_REQUEST = 1'b1;

    // placement modes (any other code acts as first fit)
    localparam logic [MODE_W-1:0] MODE_FIRST = 2'd0;
    localparam logic [MODE_W-1:0] MODE_BEST  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_WORST = 2'd2;

    // result status
    localparam logic [STATUS_W-1:0] STAT_DONE   = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_NOFIT  = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_BADIDX = 2'd2;

endpackage

// File: rtl/pfa_table.sv
// ----------------------------------------------------------------------------
// pfa_table - free space table
// One-port-write, one-port-read synchronous RAM with per-entry valid bits;
// an entry never written since reset reads as zero.
// ----------------------------------------------------------------------------
module pfa_table #(
    parameter int PARTITIONS = pfa_pkg::DEF_PARTITIONS,
    parameter int SIZE_BITS  = pfa_pkg::DEF_SIZE_BITS,
    localparam int IW = (PARTITIONS > 1) ? $clog2(PARTITIONS) : 1
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 wr_en,
    input  logic [IW-1:0]        wr_addr,
    input  logic [SIZE_BITS-1:0] wr_data,
    input  logic                 rd_en,
    input  logic [IW-1:0]        rd_addr,
    output logic [SIZE_BITS-1:0] rd_data
);

    logic [SIZE_BITS-1:0]  mem [PARTITIONS];
    logic [SIZE_BITS-1:0]  mem_q;
    logic [PARTITIONS-1:0] valid_reg;
    logic                  valid_q_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            mem_q <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg   <= '0;
            valid_q_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                valid_q_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = valid_q_reg ? mem_q : '0;

endmodule

// File: rtl/partition_fit_allocator_top.sv
// ----------------------------------------------------------------------------
// partition_fit_allocator_top - first / best / worst fit partition allocator
// Loads partition sizes into a free space table and serves allocation
// requests by scanning the table and shrinking the chosen entry.
// ----------------------------------------------------------------------------
// Sequence: a load writes the table on acceptance, then moves its result to
//   the output slot from ST_DONE; a request scans L = min(num_partitions,
//   PARTITIONS) entries in ST_SCAN, then passes ST_LAST, ST_UPDATE and ST_DONE
//   (a count of zero skips the scan and goes straight to ST_UPDATE).
// Throughput: one transaction at a time, accepted only in ST_IDLE; ST_DONE
//   waits until the output slot is free. The scan makes one RAM read per cycle.
// Reset: synchronous, active low; the table reads as all zero after reset
//   (valid bits cleared at once, no clearing pass), mode first fit, 16 entries.
// ----------------------------------------------------------------------------
module partition_fit_allocator_top #(
    parameter int PARTITIONS = pfa_pkg::DEF_PARTITIONS,
    parameter int SIZE_BITS  = pfa_pkg::DEF_SIZE_BITS
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration
    input  logic                            cfg_we,
    input  logic [pfa_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [pfa_pkg::CFG_DATA_W-1:0]  cfg_data,
    // input transactions
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [pfa_pkg::FUNC_W-1:0]      s_func,
    input  logic [pfa_pkg::PIDX_W-1:0]      s_partition_index,
    input  logic [pfa_pkg::SIZE_W-1:0]      s_size,
    // result transactions
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [pfa_pkg::STATUS_W-1:0]    m_status,
    output logic [pfa_pkg::PIDX_W-1:0]      m_chosen_partition,
    output logic [pfa_pkg::SIZE_W-1:0]      m_remaining_after
);

    // table address width, scan count width (holds PARTITIONS itself),
    // and a compare width covering both the table word and the request size
    localparam int IW = (PARTITIONS > 1) ? $clog2(PARTITIONS) : 1;
    localparam int CW = $clog2(PARTITIONS + 1);
    localparam int XW = (SIZE_BITS > pfa_pkg::SIZE_W) ? SIZE_BITS : pfa_pkg::SIZE_W;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SCAN   = 3'd1;  // issuing table reads
    localparam logic [2:0] ST_LAST   = 3'd2;  // last read data arriving
    localparam logic [2:0] ST_UPDATE = 3'd3;  // write back chosen entry
    localparam logic [2:0] ST_DONE   = 3'd4;  // hand result to output slot

    // ---------------------------------------------------------------- config
    logic [pfa_pkg::MODE_W-1:0] mode_reg;
    logic [pfa_pkg::NUMP_W-1:0] nump_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= pfa_pkg::MODE_RESET;
            nump_reg <= pfa_pkg::NUMP_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                pfa_pkg::CFG_ALLOC_MODE:     mode_reg <= cfg_data[pfa_pkg::MODE_W-1:0];
                pfa_pkg::CFG_NUM_PARTITIONS: nump_reg <= cfg_data[pfa_pkg::NUMP_W-1:0];
                default: ;
            endcase
        end
    end

    // search count, clamped to the table depth
    logic [CW-1:0] limit;
    assign limit = (32'(nump_reg) > 32'(PARTITIONS)) ? CW'(PARTITIONS) : CW'(nump_reg);

    // ------------------------------------------------------------ sequencer
    logic [2:0]                   state_reg;
    logic [pfa_pkg::SIZE_W-1:0]   size_reg;       // requested size
    logic [CW-1:0]                rd_cnt_reg;     // next address to issue
    logic [CW-1:0]                limit_reg;
    logic                         rd_pend_reg;    // read data valid this cycle
    logic [IW-1:0]                rd_idx_reg;     // address of that data
    logic                         found_reg;
    logic [SIZE_BITS-1:0]         best_reg;
    logic [IW-1:0]                best_idx_reg;

    // pending result, moved to the output slot in ST_DONE
    logic [pfa_pkg::STATUS_W-1:0] res_status_reg;
    logic [pfa_pkg::PIDX_W-1:0]   res_idx_reg;
    logic [pfa_pkg::SIZE_W-1:0]   res_rem_reg;

    logic                         m_valid_reg;
    logic [pfa_pkg::STATUS_W-1:0] m_status_reg;
    logic [pfa_pkg::PIDX_W-1:0]   m_idx_reg;
    logic [pfa_pkg::SIZE_W-1:0]   m_rem_reg;

    logic                 s_fire;
    logic                 load_bad;
    logic                 slot_free;

    logic                 tbl_wr_en;
    logic [IW-1:0]        tbl_wr_addr;
    logic [SIZE_BITS-1:0] tbl_wr_data;
    logic                 tbl_rd_en;
    logic [SIZE_BITS-1:0] tbl_rd_data;

    logic                 fits;
    logic                 take;
    logic [XW-1:0]        space_x;
    logic [XW-1:0]        size_x;
    logic [XW-1:0]        best_x;
    logic [SIZE_BITS-1:0] best_left;

    assign s_ready   = (state_reg == ST_IDLE);
    assign s_fire    = s_valid && s_ready;
    assign load_bad  = (32'(s_partition_index) >= 32'(PARTITIONS));
    assign slot_free = !m_valid_reg || m_ready;

    // candidate compare against the running pick; ties keep the lower index
    assign space_x = XW'(tbl_rd_data);
    assign size_x  = XW'(size_reg);
    assign best_x  = XW'(best_reg);
    assign fits    = (space_x >= size_x);
    assign take    = fits && (!found_reg
                     || ((mode_reg == pfa_pkg::MODE_BEST)  && (space_x < best_x))
                     || ((mode_reg == pfa_pkg::MODE_WORST) && (space_x > best_x)));

    assign best_left = SIZE_BITS'(best_x - size_x);

    // table accesses: loads write on acceptance, requests write at update
    always_comb begin
        tbl_wr_en   = 1'b0;
        tbl_wr_addr = best_idx_reg;
        tbl_wr_data = best_left;
        if (s_fire && (s_func == pfa_pkg::FUNC_LOAD) && !load_bad) begin
            tbl_wr_en   = 1'b1;
            tbl_wr_addr = IW'(s_partition_index);
            tbl_wr_data = SIZE_BITS'(s_size);
        end else if ((state_reg == ST_UPDATE) && found_reg) begin
            tbl_wr_en = 1'b1;
        end
    end

    assign tbl_rd_en = (state_reg == ST_SCAN);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            rd_pend_reg <= 1'b0;
            found_reg   <= 1'b0;
        end else begin
            rd_pend_reg <= tbl_rd_en;
            case (state_reg)
                ST_IDLE: begin
                    if (s_fire) begin
                        size_reg   <= s_size;
                        found_reg  <= 1'b0;
                        rd_cnt_reg <= '0;
                        limit_reg  <= limit;
                        if (s_func == pfa_pkg::FUNC_LOAD) begin
                            if (load_bad) begin
                                res_status_reg <= pfa_pkg::STAT_BADIDX;
                                res_idx_reg    <= '0;
                                res_rem_reg    <= '0;
                            end else begin
                                res_status_reg <= pfa_pkg::STAT_DONE;
                                res_idx_reg    <= s_partition_index;
                                res_rem_reg    <= pfa_pkg::SIZE_W'(SIZE_BITS'(s_size));
                            end
                            state_reg <= ST_DONE;
                        end else if (limit == '0) begin
                            state_reg <= ST_UPDATE;
                        end else begin
                            state_reg <= ST_SCAN;
                        end
                    end
                end
                ST_SCAN: begin
                    rd_idx_reg <= rd_cnt_reg[IW-1:0];
                    rd_cnt_reg <= rd_cnt_reg + 1'b1;
                    if (rd_cnt_reg == limit_reg - 1'b1) begin
                        state_reg <= ST_LAST;
                    end
                end
                ST_LAST: begin
                    state_reg <= ST_UPDATE;
                end
                ST_UPDATE: begin
                    if (found_reg) begin
                        res_status_reg <= pfa_pkg::STAT_DONE;
                        res_idx_reg    <= pfa_pkg::PIDX_W'(best_idx_reg);
                        res_rem_reg    <= pfa_pkg::SIZE_W'(best_left);
                    end else begin
                        res_status_reg <= pfa_pkg::STAT_NOFIT;
                        res_idx_reg    <= '0;
                        res_rem_reg    <= '0;
                    end
                    state_reg <= ST_DONE;
                end
                ST_DONE: begin
                    if (slot_free) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase

            // evaluate read data as it returns (during scan and its tail)
            if (rd_pend_reg && take) begin
                found_reg    <= 1'b1;
                best_reg     <= tbl_rd_data;
                best_idx_reg <= rd_idx_reg;
            end
        end
    end

    // ---------------------------------------------------------- output slot
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if ((state_reg == ST_DONE) && slot_free) begin
            m_valid_reg  <= 1'b1;
            m_status_reg <= res_status_reg;
            m_idx_reg    <= res_idx_reg;
            m_rem_reg    <= res_rem_reg;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_status           = m_status_reg;
    assign m_chosen_partition = m_idx_reg;
    assign m_remaining_after  = m_rem_reg;

    // ---------------------------------------------------------------- table
    pfa_table #(
        .PARTITIONS (PARTITIONS),
        .SIZE_BITS  (SIZE_BITS)
    ) u_table (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (tbl_wr_en),
        .wr_addr (tbl_wr_addr),
        .wr_data (tbl_wr_data),
        .rd_en   (tbl_rd_en),
        .rd_addr (rd_cnt_reg[IW-1:0]),
        .rd_data (tbl_rd_data)
    );

`ifndef SYNTH
    // no read data left in flight once a new transaction can be taken
    a_idle_no_read: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !rd_pend_reg)
        else $error("read data pending while idle");

    // table writes only on a load acceptance or the request write-back
    a_write_window: assert property (@(posedge aclk) disable iff (!aresetn)
        tbl_wr_en |-> ((state_reg == ST_IDLE) || (state_reg == ST_UPDATE)))
        else $error("table write outside load or update");

    // a granted entry always holds at least the requested size
    a_grant_fits: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_UPDATE) && found_reg) |-> (best_x >= size_x))
        else $error("granted entry smaller than request");

    // a pending result is never overwritten before it is taken
    a_slot_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |=> (m_valid_reg && $stable(m_status_reg)
                                      && $stable(m_idx_reg) && $stable(m_rem_reg)))
        else $error("result slot overwritten while stalled");
`endif

endmodule
